FILE: design/tccw_pkg.sv
// Shared types, codes and helpers for the text console cell writer.
// No dependencies; imported by the controller, the datapath and the top level.
package tccw_pkg;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;

    // Port widths
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int COLOUR_W    = 8;
    localparam int NUMBER_W    = 32;
    localparam int CELL_ADDR_W = 11;
    localparam int CELL_WORD_W = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 32;

    // Digit stack: ten decimal digits at most
    localparam int DIGITS_MAX = 10;
    localparam int DIG_IDX_W  = $clog2(DIGITS_MAX);
    localparam int DIG_CNT_W  = $clog2(DIGITS_MAX + 1);

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEX  = 2'd2;

    // Character codes and the number colour
    localparam logic [CHAR_W-1:0]   CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]   CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]   CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0]   CH_MINUS     = 8'h2D;
    localparam logic [CHAR_W-1:0]   CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0]   CH_X         = 8'h78;
    localparam logic [COLOUR_W-1:0] DIGIT_COLOUR = 8'd15;

    // Reciprocal of ten, exact for 32-bit dividends with a shift of 35
    localparam logic [NUMBER_W-1:0] RECIP10 = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_EXTRACT,
        ST_SIGN,
        ST_PFX0,
        ST_PFX1,
        ST_DIGIT
    } t_state;

    typedef enum logic [2:0] {
        PUT_INPUT,
        PUT_MINUS,
        PUT_ZERO,
        PUT_X,
        PUT_DIGIT
    } t_put_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     extract;
        logic     put;
        t_put_sel sel;
        logic     final_char;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
        logic mag_next_zero;
        logic negative;
        logic hex;
        logic cnt_one;
    } t_status;

    // Uppercase hex glyph of one digit
    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] base;
        base = (d < 4'd10) ? 8'h30 : 8'h37;
        return base + {4'b0000, d};
    endfunction

endpackage

FILE: design/text_console_cell_writer_unit.sv
// A character item is put through the single output register as one word; a number item
// first has its digits extracted one a cycle (reciprocal multiplier for decimal, nibbles for
// hex), then puts its sign or 0x prefix and its digits one word a cycle through the same
// output register, whenever the output is free to take them.
// Reset (synchronous, active low) homes the cursor and empties the output.
// Depends on tccw_pkg, tccw_ctrl and tccw_datapath.
module text_console_cell_writer_unit #(
    parameter int SCREEN_WIDTH  = tccw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tccw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] char_code, [15:8] colour, [47:16] number
    input  logic [tccw_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] func
    input  logic [tccw_pkg::FUNC_W-1:0]         i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [10:0] cell_address, [26:11] cell_word, [31:27] zero
    output logic [tccw_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast
);
    import tccw_pkg::*;

    t_cmd                   cmd;
    t_status                status;
    logic [CELL_ADDR_W-1:0] cell_address;
    logic [CELL_WORD_W-1:0] cell_word;

    // Sequencer
    tccw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_func   (i_s_tuser),
        .i_status (status),
        .o_ready  (o_s_tready),
        .o_cmd    (cmd)
    );

    // Cursor, digits and output register
    tccw_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_s_tuser),
        .i_char_code    (i_s_tdata[7:0]),
        .i_colour       (i_s_tdata[15:8]),
        .i_number       (i_s_tdata[47:16]),
        .i_out_ready    (i_m_tready),
        .o_status       (status),
        .o_out_valid    (o_m_tvalid),
        .o_cell_address (cell_address),
        .o_cell_word    (cell_word),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {{(OUT_DATA_W - CELL_ADDR_W - CELL_WORD_W){1'b0}}, cell_word, cell_address};

    // A character item keeps the input closed for the next cycle
    a_char_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == FUNC_CHAR) |=> !o_s_tready)
        else $error("input open right after a character word");

    // The unused kind leaves the input open
    a_unused_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser != FUNC_CHAR && i_s_tuser != FUNC_DEC
         && i_s_tuser != FUNC_HEX) |=> o_s_tready)
        else $error("unused kind started work");

    // Every written cell lies on the screen
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[CELL_ADDR_W-1:0]) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)))
        else $error("cell address beyond the screen");

endmodule

FILE: design/tccw_ctrl.sv
// Sequencer for the text console cell writer: puts each character item and walks each
// number item through extraction, sign or prefix and digit output. Depends on tccw_pkg.
module tccw_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [tccw_pkg::FUNC_W-1:0] i_func,
    input  tccw_pkg::t_status        i_status,
    output logic                     o_ready,
    output tccw_pkg::t_cmd           o_cmd
);
    import tccw_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        FUNC_CHAR: n_state = ST_CHAR;
                        FUNC_DEC:  n_state = ST_EXTRACT;
                        FUNC_HEX:  n_state = ST_EXTRACT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CHAR: begin
                if (i_status.slot_free) n_state = ST_IDLE;
            end
            ST_EXTRACT: begin
                if (i_status.mag_next_zero) begin
                    if (i_status.hex)           n_state = ST_PFX0;
                    else if (i_status.negative) n_state = ST_SIGN;
                    else                        n_state = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (i_status.slot_free) n_state = ST_DIGIT;
            end
            ST_PFX0: begin
                if (i_status.slot_free) n_state = ST_PFX1;
            end
            ST_PFX1: begin
                if (i_status.slot_free) n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (i_status.slot_free && i_status.cnt_one) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_ready          = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.extract    = 1'b0;
        o_cmd.put        = 1'b0;
        o_cmd.sel        = PUT_INPUT;
        o_cmd.final_char = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_CHAR: begin
                o_cmd.put        = 1'b1;
                o_cmd.sel        = PUT_INPUT;
                o_cmd.final_char = 1'b1;
            end
            ST_EXTRACT: begin
                o_cmd.extract = 1'b1;
            end
            ST_SIGN: begin
                o_cmd.put = 1'b1;
                o_cmd.sel = PUT_MINUS;
            end
            ST_PFX0: begin
                o_cmd.put = 1'b1;
                o_cmd.sel = PUT_ZERO;
            end
            ST_PFX1: begin
                o_cmd.put = 1'b1;
                o_cmd.sel = PUT_X;
            end
            ST_DIGIT: begin
                o_cmd.put        = 1'b1;
                o_cmd.sel        = PUT_DIGIT;
                o_cmd.final_char = i_status.cnt_one;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/tccw_datapath.sv
// Datapath of the text console cell writer: cursor, digit extraction,
// digit stack and the output word register. Depends on tccw_pkg.
module tccw_datapath #(
    parameter int SCREEN_WIDTH  = tccw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tccw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tccw_pkg::t_cmd                   i_cmd,
    input  logic [tccw_pkg::FUNC_W-1:0]      i_func,
    input  logic [tccw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tccw_pkg::COLOUR_W-1:0]    i_colour,
    input  logic [tccw_pkg::NUMBER_W-1:0]    i_number,
    input  logic                             i_out_ready,
    output tccw_pkg::t_status                o_status,
    output logic                             o_out_valid,
    output logic [tccw_pkg::CELL_ADDR_W-1:0] o_cell_address,
    output logic [tccw_pkg::CELL_WORD_W-1:0] o_cell_word,
    output logic                             o_last
);
    import tccw_pkg::*;

    localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int FULL_W = (ROW_W + COL_W > CELL_ADDR_W) ? ROW_W + COL_W : CELL_ADDR_W;
    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_END  = ROW_W'(SCREEN_HEIGHT);
    localparam logic [FULL_W-1:0] WIDTH_F  = FULL_W'(SCREEN_WIDTH);

    // Cursor and item registers
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [NUMBER_W-1:0]  r_mag;
    logic                 r_neg;
    logic                 r_hex;
    logic [CHAR_W-1:0]    r_char;
    logic [COLOUR_W-1:0]  r_colour;
    logic [3:0]           r_digits [DIGITS_MAX];
    logic [DIG_CNT_W-1:0] r_cnt;

    // Output register
    logic                   r_out_valid;
    logic [CELL_ADDR_W-1:0] r_out_addr;
    logic [CELL_WORD_W-1:0] r_out_word;
    logic                   r_out_last;

    logic                  slot_free;
    logic                  do_put;
    logic [2*NUMBER_W-1:0] prod;
    logic [NUMBER_W-1:0]   q_next;
    logic [3:0]            q10_lo;
    logic [3:0]            d_next;
    logic [DIG_CNT_W-1:0]  cnt_dec;
    logic [CHAR_W-1:0]     put_ch;
    logic [COLOUR_W-1:0]   put_colour;
    logic [ROW_W-1:0]      n_row;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      e_row;
    logic [COL_W-1:0]      e_col;
    logic [CHAR_W-1:0]     e_ch;
    logic [COLOUR_W-1:0]   e_colour;
    logic                  emit;
    logic                  e_last;
    logic [FULL_W-1:0]     e_addr;

    assign slot_free = !r_out_valid || i_out_ready;
    assign do_put    = i_cmd.put && slot_free;
    assign cnt_dec   = r_cnt - 1'b1;

    // Next digit: nibble for hex, reciprocal multiply for decimal
    assign prod   = {{NUMBER_W{1'b0}}, r_mag} * {{NUMBER_W{1'b0}}, RECIP10};
    assign q10_lo = {prod[35], 3'b000} + {prod[37:35], 1'b0};
    always_comb begin
        if (r_hex) begin
            q_next = {4'b0000, r_mag[NUMBER_W-1:4]};
            d_next = r_mag[3:0];
        end else begin
            q_next = {3'b000, prod[2*NUMBER_W-1:35]};
            d_next = r_mag[3:0] - q10_lo;
        end
    end

    // Select the character to put
    always_comb begin
        put_colour = DIGIT_COLOUR;
        case (i_cmd.sel)
            PUT_INPUT: begin
                put_ch     = r_char;
                put_colour = r_colour;
            end
            PUT_MINUS: put_ch = CH_MINUS;
            PUT_ZERO:  put_ch = CH_ZERO;
            PUT_X:     put_ch = CH_X;
            PUT_DIGIT: put_ch = f_digit_char(r_digits[cnt_dec[DIG_IDX_W-1:0]]);
            default:   put_ch = CH_SPACE;
        endcase
    end

    // Cursor move and cell write for one character
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        emit     = 1'b0;
        e_ch     = put_ch;
        e_colour = put_colour;
        if (put_ch == CH_NEWLINE) begin
            n_col = '0;
            if (r_row != ROW_END) n_row = r_row + 1'b1;
        end else if (put_ch == CH_BACKSPACE) begin
            if (r_row != '0 || r_col != '0) begin
                emit     = 1'b1;
                e_ch     = CH_SPACE;
                e_colour = DIGIT_COLOUR;
                if (r_col == '0) begin
                    n_row = r_row - 1'b1;
                    n_col = COL_LAST;
                end else begin
                    n_col = r_col - 1'b1;
                end
            end
        end else if (r_row != ROW_END) begin
            emit = 1'b1;
            if (r_col == COL_LAST) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        // Backspace writes the cell it steps back to, others the current cell
        if (put_ch == CH_BACKSPACE) begin
            e_row = n_row;
            e_col = n_col;
        end else begin
            e_row = r_row;
            e_col = r_col;
        end
        // Reaching the bottom marks this word last; printable words after it are dropped
        e_last = i_cmd.final_char || (n_row == ROW_END);
    end

    assign e_addr = FULL_W'(e_row) * WIDTH_F + FULL_W'(e_col);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_put) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.extract) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_put && i_cmd.sel == PUT_DIGIT) begin
                r_cnt <= cnt_dec;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg    <= (i_func == FUNC_DEC) && i_number[NUMBER_W-1];
            r_hex    <= (i_func == FUNC_HEX);
            r_char   <= i_char_code;
            r_colour <= i_colour;
            if ((i_func == FUNC_DEC) && i_number[NUMBER_W-1]) begin
                r_mag <= (~i_number) + 1'b1;
            end else begin
                r_mag <= i_number;
            end
        end else if (i_cmd.extract) begin
            r_mag <= q_next;
            r_digits[r_cnt[DIG_IDX_W-1:0]] <= d_next;
        end
        if (do_put && emit) begin
            r_out_addr <= e_addr[CELL_ADDR_W-1:0];
            r_out_word <= {e_colour, e_ch};
            r_out_last <= e_last;
        end
    end

    assign o_status.slot_free     = slot_free;
    assign o_status.mag_next_zero = (q_next == '0);
    assign o_status.negative      = r_neg;
    assign o_status.hex           = r_hex;
    assign o_status.cnt_one       = (r_cnt == DIG_CNT_W'(1));

    assign o_out_valid    = r_out_valid;
    assign o_cell_address = r_out_addr;
    assign o_cell_word    = r_out_word;
    assign o_last         = r_out_last;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for the text console cell writer: streams character and number words
// into the block and checks every cell write against a cursor predictor.
// Depends on tccw_pkg and text_console_cell_writer_unit.
module testbench;
    import tccw_pkg::*;

    localparam int SCREEN_W      = SCREEN_WIDTH_DEF;
    localparam int SCREEN_H      = SCREEN_HEIGHT_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 50;
    // Item kind the block leaves alone
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAR_W-1:0]   ch;
        logic [COLOUR_W-1:0] attr;
        logic [NUMBER_W-1:0] number;
    } t_console_item;

    typedef struct packed {
        logic [CELL_ADDR_W-1:0] addr;
        logic [CELL_WORD_W-1:0] word;
        logic                   is_last;
    } t_cell_write;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [FUNC_W-1:0]     i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;

    logic        recv_ready = 1'b0;
    logic        hold_off   = 1'b0;
    logic        hold_done  = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned send_wait  = 0;
    int unsigned recv_wait  = 0;
    int unsigned cycle_cnt  = 0;

    // Cursor copy and expectations
    logic [4:0]  cur_row = '0;
    logic [6:0]  cur_col = '0;
    t_cell_write item_writes[$];
    t_cell_write cell_writes_due[$];
    t_console_item words_to_send[$];

    int unsigned items_taken   = 0;
    int unsigned writes_seen   = 0;
    int unsigned fail_cnt      = 0;
    int unsigned bottom_drops  = 0;
    int unsigned kind_cnt[4]   = '{0, 0, 0, 0};

    assign i_m_tready = recv_ready && !hold_off;

    text_console_cell_writer_unit #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Record one screen write at the cursor, dropped below the last row
    function automatic void write_at_cursor(input logic [CHAR_W-1:0] ch,
                                            input logic [COLOUR_W-1:0] attr);
        t_cell_write w;
        if (cur_row >= SCREEN_H) begin
            bottom_drops++;
            return;
        end
        w.addr    = CELL_ADDR_W'(cur_row * SCREEN_W + cur_col);
        w.word    = {attr, ch};
        w.is_last = 1'b0;
        item_writes.push_back(w);
    endfunction

    // Apply one character to the cursor: newline, backspace or a printable glyph
    function automatic void put_glyph(input logic [CHAR_W-1:0] ch,
                                      input logic [COLOUR_W-1:0] attr);
        if (ch == CH_NEWLINE) begin
            cur_col = '0;
            if (cur_row < SCREEN_H)
                cur_row++;
        end else if (ch == CH_BACKSPACE) begin
            if (cur_row != 0 || cur_col != 0) begin
                if (cur_col == 0) begin
                    cur_row--;
                    cur_col = 7'(SCREEN_W - 1);
                end else begin
                    cur_col--;
                end
                write_at_cursor(CH_SPACE, DIGIT_COLOUR);
            end
        end else if (cur_row >= SCREEN_H) begin
            bottom_drops++;
        end else begin
            write_at_cursor(ch, attr);
            cur_col++;
            if (cur_col >= SCREEN_W) begin
                cur_col = '0;
                cur_row++;
            end
        end
    endfunction

    // Print a magnitude most significant digit first, no leading zeros
    function automatic void put_magnitude(input logic [NUMBER_W-1:0] mag,
                                          input int unsigned radix);
        logic [3:0] digs [10];
        int         n;
        logic [3:0] d;
        n = 0;
        if (mag == 0) begin
            put_glyph(CH_ZERO, DIGIT_COLOUR);
            return;
        end
        while (mag != 0) begin
            digs[n] = 4'(mag % radix);
            mag     = mag / radix;
            n++;
        end
        while (n > 0) begin
            n--;
            d = digs[n];
            put_glyph((d < 4'd10) ? CH_ZERO + {4'h0, d} : 8'h41 + {4'h0, d} - 8'd10,
                      DIGIT_COLOUR);
        end
    endfunction

    // Work out the cell writes one accepted word causes
    function automatic void predict_cell_writes(input t_console_item it);
        t_cell_write w;
        logic [NUMBER_W-1:0] mag;
        item_writes.delete();
        case (it.func)
            FUNC_CHAR: begin
                put_glyph(it.ch, it.attr);
            end
            FUNC_DEC: begin
                mag = it.number;
                if (mag[NUMBER_W-1]) begin
                    put_glyph(CH_MINUS, DIGIT_COLOUR);
                    mag = ~mag + 32'd1;
                end
                put_magnitude(mag, 10);
            end
            FUNC_HEX: begin
                put_glyph(CH_ZERO, DIGIT_COLOUR);
                put_glyph(CH_X, DIGIT_COLOUR);
                put_magnitude(it.number, 16);
            end
            default: begin
            end
        endcase
        if (item_writes.size() > 0) begin
            w = item_writes.pop_back();
            w.is_last = 1'b1;
            item_writes.push_back(w);
        end
        foreach (item_writes[i])
            cell_writes_due.push_back(item_writes[i]);
    endfunction

    // Idle draw; every fourth stretch of sixteen words runs without gaps
    function automatic int unsigned draw_pause();
        if ((items_taken / 16) % 4 == 3)
            return 0;
        if ($urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [NUMBER_W-1:0] shaped_number();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2: return 32'(0 - $urandom_range(1, 99999));
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Random word with weighted newlines and backspaces
    function automatic t_console_item random_item(input int unsigned nl_pct,
                                                  input int unsigned bs_pct);
        t_console_item it;
        int unsigned   roll;
        it.func   = FUNC_CHAR;
        it.ch     = 8'($urandom);
        it.attr   = 8'($urandom);
        it.number = $urandom;
        roll      = $urandom_range(0, 99);
        if (roll < nl_pct) begin
            it.ch = CH_NEWLINE;
        end else if (roll < nl_pct + bs_pct) begin
            it.ch = CH_BACKSPACE;
        end else if (roll >= 60 && roll < 80) begin
            it.func   = FUNC_DEC;
            it.number = shaped_number();
        end else if (roll >= 80 && roll < 97) begin
            it.func   = FUNC_HEX;
            it.number = shaped_number();
        end else if (roll >= 97) begin
            it.func = FUNC_NONE;
        end
        return it;
    endfunction

    task automatic queue_word(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                              input logic [COLOUR_W-1:0] attr,
                              input logic [NUMBER_W-1:0] number);
        t_console_item it;
        it.func   = func;
        it.ch     = ch;
        it.attr   = attr;
        it.number = number;
        words_to_send.push_back(it);
    endtask

    // Sender: present queued words, with random idle gaps between some of them
    always @(posedge i_clk) begin : sender
        t_console_item it;
        int unsigned   pause;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_wait  <= 0;
        end else if (i_s_tvalid && o_s_tready) begin
            pause = draw_pause();
            if (pause == 0 && words_to_send.size() > 0) begin
                it = words_to_send.pop_front();
                i_s_tdata <= {it.number, it.attr, it.ch};
                i_s_tuser <= it.func;
            end else begin
                i_s_tvalid <= 1'b0;
                send_wait  <= pause;
            end
        end else if (!i_s_tvalid) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (words_to_send.size() > 0) begin
                it = words_to_send.pop_front();
                i_s_tdata  <= {it.number, it.attr, it.ch};
                i_s_tuser  <= it.func;
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: stall for a random pause after some words
    always @(posedge i_clk) begin : receiver
        int unsigned pause;
        if (!i_rst_n) begin
            recv_ready <= 1'b0;
            recv_wait  <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            pause = draw_pause();
            if (pause != 0) begin
                recv_ready <= 1'b0;
                recv_wait  <= pause;
            end
        end else if (!recv_ready) begin
            if (recv_wait > 0)
                recv_wait <= recv_wait - 1;
            else
                recv_ready <= 1'b1;
        end
    end

    // Hold the output off once for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end else if (hold_off) begin
            if (hold_left == 0) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Check output words first, then predict from the input word taken this edge
    always @(posedge i_clk) begin : scoreboard
        t_cell_write   want;
        t_console_item got_item;
        if (!i_rst_n) begin
            cur_row = '0;
            cur_col = '0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (cell_writes_due.size() == 0) begin
                    $error("unexpected cell write: address %0d word %h",
                           o_m_tdata[10:0], o_m_tdata[26:11]);
                    fail_cnt++;
                end else begin
                    want = cell_writes_due.pop_front();
                    writes_seen++;
                    if (o_m_tdata[10:0] !== want.addr) begin
                        $error("cell_address: expected %0d, got %0d",
                               want.addr, o_m_tdata[10:0]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[26:11] !== want.word) begin
                        $error("cell_word: expected %h, got %h",
                               want.word, o_m_tdata[26:11]);
                        fail_cnt++;
                    end
                    if (o_m_tlast !== want.is_last) begin
                        $error("last: expected %b, got %b", want.is_last, o_m_tlast);
                        fail_cnt++;
                    end
                    if (o_m_tdata[31:27] !== 5'd0) begin
                        $error("pad: expected 0, got %h", o_m_tdata[31:27]);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                got_item.func   = i_s_tuser;
                got_item.ch     = i_s_tdata[7:0];
                got_item.attr   = i_s_tdata[15:8];
                got_item.number = i_s_tdata[47:16];
                predict_cell_writes(got_item);
                kind_cnt[got_item.func]++;
                items_taken++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // Directed: origin backspace, byte extremes, number edge values
        queue_word(FUNC_CHAR, CH_BACKSPACE, 8'h1F, 32'h0);
        queue_word(FUNC_CHAR, CH_NEWLINE, 8'h07, 32'h0);
        queue_word(FUNC_CHAR, CH_BACKSPACE, 8'h07, 32'h0);
        queue_word(FUNC_CHAR, 8'h7A, 8'h1E, 32'h0);
        queue_word(FUNC_CHAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        queue_word(FUNC_CHAR, 8'h00, 8'h00, 32'h0);
        queue_word(FUNC_DEC, 8'h00, 8'h00, 32'h0);
        queue_word(FUNC_DEC, CH_NEWLINE, 8'hFF, 32'h8000_0000);
        queue_word(FUNC_DEC, 8'hFF, 8'h00, 32'h7FFF_FFFF);
        queue_word(FUNC_DEC, CH_BACKSPACE, 8'h00, 32'hFFFF_FFFF);
        queue_word(FUNC_DEC, 8'h41, 8'h42, 32'd9);
        queue_word(FUNC_DEC, 8'h41, 8'h42, 32'd10);
        queue_word(FUNC_HEX, 8'h00, 8'h00, 32'h0);
        queue_word(FUNC_HEX, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        queue_word(FUNC_HEX, 8'h55, 8'hAA, 32'h0000_00A5);
        queue_word(FUNC_HEX, 8'h0A, 8'h0F, 32'h8000_0000);
        queue_word(FUNC_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        queue_word(FUNC_NONE, CH_NEWLINE, 8'h00, 32'h0);
        queue_word(FUNC_CHAR, CH_BACKSPACE, 8'h33, 32'h0);
        queue_word(FUNC_CHAR, CH_NEWLINE, 8'h33, 32'h0);
        queue_word(FUNC_CHAR, 8'h80, 8'h7F, 32'h0);

        // Long lines: few newlines so the column wraps
        repeat (25) words_to_send.push_back(random_item(4, 6));
        // Run the cursor to the bottom; words landing there are dropped
        for (int i = 0; i < 28; i++) begin
            queue_word(FUNC_CHAR, CH_NEWLINE, 8'($urandom), $urandom);
            if ($urandom_range(0, 2) == 0)
                words_to_send.push_back(random_item(0, 0));
        end
        // Back up from the bottom and print across the last cell
        repeat (30) words_to_send.push_back(random_item(5, 22));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every word sent, every cell write seen
        while (words_to_send.size() != 0 || i_s_tvalid || cell_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb: %0d words taken (%0d char, %0d decimal, %0d hex, %0d unused kind)",
                 items_taken, kind_cnt[FUNC_CHAR], kind_cnt[FUNC_DEC], kind_cnt[FUNC_HEX],
                 kind_cnt[FUNC_NONE]);
        $display("tb: %0d cell writes checked, %0d characters dropped below the last row",
                 writes_seen, bottom_drops);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
